// ----- src/bq_pkg.sv -----
package bq_pkg;

  localparam int unsigned COEF_WIDTH         = 24;
  localparam int unsigned SAMPLE_WIDTH_DEF   = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 20;
  localparam int unsigned CFG_IDX_W          = 3;

  localparam logic [1:0] WARMUP_SAMPLES = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] b0;
    logic signed [COEF_WIDTH-1:0] b1;
    logic signed [COEF_WIDTH-1:0] b2;
    logic signed [COEF_WIDTH-1:0] a1;
    logic signed [COEF_WIDTH-1:0] a2;
  } coef_t;

endpackage

// ----- src/bq_mac.sv -----
module bq_mac #(
  parameter int unsigned SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
  input  bq_pkg::coef_t            coef_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x0_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y2_i,
  output logic signed [SAMPLE_WIDTH-1:0] y_o,
  output logic                           clip_o
);
  import bq_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned QW     = ACC_W - COEF_FRAC_BITS;
  localparam int unsigned EXT_W  = (QW > SAMPLE_WIDTH) ? QW : SAMPLE_WIDTH;

  localparam logic signed [EXT_W-1:0] MAX_V =
    {{(EXT_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] MIN_V = ~MAX_V;

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic                     round_up;
  logic signed [QW-1:0]     quot;
  logic signed [EXT_W-1:0]  quot_ext;

  assign p_b0 = PROD_W'(coef_i.b0) * PROD_W'(x0_i);
  assign p_b1 = PROD_W'(coef_i.b1) * PROD_W'(x1_i);
  assign p_b2 = PROD_W'(coef_i.b2) * PROD_W'(x2_i);
  assign p_a1 = PROD_W'(coef_i.a1) * PROD_W'(y1_i);
  assign p_a2 = PROD_W'(coef_i.a2) * PROD_W'(y2_i);

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2);

  // truncate toward zero: floor, then step up for negative inexact sums
  assign round_up = acc[ACC_W-1] & (|acc[COEF_FRAC_BITS-1:0]);
  assign quot     = $signed(acc[ACC_W-1:COEF_FRAC_BITS]) + $signed(QW'(round_up));
  assign quot_ext = EXT_W'(quot);

  always_comb begin
    if (quot_ext > MAX_V) begin
      y_o    = MAX_V[SAMPLE_WIDTH-1:0];
      clip_o = 1'b1;
    end else if (quot_ext < MIN_V) begin
      y_o    = MIN_V[SAMPLE_WIDTH-1:0];
      clip_o = 1'b1;
    end else begin
      y_o    = quot_ext[SAMPLE_WIDTH-1:0];
      clip_o = 1'b0;
    end
  end

endmodule

// ----- src/biquad_iir_filter_top.sv -----
// Direct form I biquad on signed PCM samples. Load b0, b1, b2, a1, a2 (already
// divided by a0, signed Q3.20 by default) through the config port while the
// filter is idle; a1 and a2 are subtracted. One sample is taken every clock
// cycle unless the output stalls; results pass the s1 and output registers.
// The feedback path sets the rate: the five coefficient products, their sum,
// truncation toward zero and saturation are combinational, as each output feeds
// the next sample. Assert start_of_record on the first sample of a record to
// clear history; the first two samples of a record give 0, as does the filter
// straight after reset. clipped marks a saturated output.
module biquad_iir_filter_top #(
  parameter int unsigned SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bq_pkg::COEF_WIDTH-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  input  logic                              start_of_record_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  output logic                              clipped_o
);
  import bq_pkg::*;

  coef_t coef_q;

  logic                           s1_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_q;
  logic                           s1_sor_q;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_clip_q;

  logic signed [SAMPLE_WIDTH-1:0] x1_q, x2_q, y1_q, y2_q;
  logic [1:0]                     warm_q;

  logic                           advance;
  logic signed [SAMPLE_WIDTH-1:0] h_x1, h_x2, h_y1, h_y2;
  logic [1:0]                     warm_eff;
  logic                           warm_done;
  logic signed [SAMPLE_WIDTH-1:0] mac_y;
  logic                           mac_clip;
  logic signed [SAMPLE_WIDTH-1:0] y_d;
  logic                           clip_d;
  logic [1:0]                     warm_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_B0:  coef_q.b0 <= cfg_data_i;
        REG_B1:  coef_q.b1 <= cfg_data_i;
        REG_B2:  coef_q.b2 <= cfg_data_i;
        REG_A1:  coef_q.a1 <= cfg_data_i;
        REG_A2:  coef_q.a2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // start marker: history seen as cleared for this sample
  assign h_x1     = s1_sor_q ? '0 : x1_q;
  assign h_x2     = s1_sor_q ? '0 : x2_q;
  assign h_y1     = s1_sor_q ? '0 : y1_q;
  assign h_y2     = s1_sor_q ? '0 : y2_q;
  assign warm_eff = s1_sor_q ? '0 : warm_q;
  assign warm_done = (warm_eff == WARMUP_SAMPLES);

  bq_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .coef_i (coef_q),
    .x0_i   (s1_x_q),
    .x1_i   (h_x1),
    .x2_i   (h_x2),
    .y1_i   (h_y1),
    .y2_i   (h_y2),
    .y_o    (mac_y),
    .clip_o (mac_clip)
  );

  assign y_d    = warm_done ? mac_y : '0;
  assign clip_d = warm_done & mac_clip;
  assign warm_d = warm_done ? warm_eff : warm_eff + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      warm_q      <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        x2_q        <= h_x1;
        x1_q        <= s1_x_q;
        y2_q        <= h_y1;
        y1_q        <= y_d;
        warm_q      <= warm_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_x_q   <= sample_in_i;
      s1_sor_q <= start_of_record_i;
    end
    if (advance) begin
      out_sample_q <= y_d;
      out_clip_q   <= clip_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

endmodule

// ----- src/bq_checker.sv -----
module bq_checker #(
  parameter int unsigned SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                           clipped_o
);

  localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_out_o) && $stable(clipped_o))
    else $error("stalled result changed");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      (sample_out_o == SAT_MAX) || (sample_out_o == SAT_MIN))
    else $error("clipped result not at a rail");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with output empty");

  a_out_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an input transfer two cycles before");

endmodule

bind biquad_iir_filter_top bq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .clipped_o    (clipped_o)
);

// ----- tb/tb_biquad_iir_filter_top.sv -----
module tb_biquad_iir_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bq_pkg::*;

  localparam int unsigned SW              = SAMPLE_WIDTH_DEF;
  localparam int          CLK_PERIOD      = 4;
  localparam int          RESET_CYCLES    = 5;
  localparam int          MAX_GAP         = 18;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          SETTLE_CYCLES   = 6;
  localparam int          WATCHDOG_LIMIT  = 4000;
  localparam int          NUM_PHASES      = 12;
  localparam int          PHASE_ITEMS     = 120;
  localparam int          PRESSURE_PHASE  = 2;
  localparam int          PRESSURE_ITEM   = 30;
  localparam int          MAX_REPORTS     = 10;

  localparam longint FIX_ONE   = longint'(1) << COEF_FRAC_BITS_DEF;
  localparam int     COEF_ONE  = 1 << COEF_FRAC_BITS_DEF;
  localparam int     COEF_HALF = COEF_ONE / 2;
  localparam int     COEF_MAX  = 2 ** (COEF_WIDTH - 1) - 1;
  localparam int     COEF_MIN  = -(2 ** (COEF_WIDTH - 1));
  localparam int     PCM_MAX   = 2 ** (SW - 1) - 1;
  localparam int     PCM_MIN   = -(2 ** (SW - 1));

  localparam int IDX_SPARE_LO = REG_A2 + 1;
  localparam int IDX_TOP      = 2 ** CFG_IDX_W - 1;

  typedef logic signed [SW-1:0]   pcm_t;
  typedef logic [COEF_WIDTH-1:0]  coef_word_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  typedef struct packed {
    pcm_t sample;
    logic clipped;
  } filt_result_t;

  typedef enum int {
    COEF_ALL_MAX,
    COEF_ALL_MIN,
    COEF_CORNERS,
    COEF_TAME,
    COEF_WILD
  } coef_style_e;

  class filter_scoreboard;
    int           coef_tab [5];
    int           x1, x2, y1, y2;
    int unsigned  warmup;
    filt_result_t expected_out [$];
    int unsigned  mismatches;

    function new();
      foreach (coef_tab[i]) coef_tab[i] = 0;
      mismatches = 0;
      clear_history();
    endfunction

    function void clear_history();
      x1 = 0;
      x2 = 0;
      y1 = 0;
      y2 = 0;
      warmup = 0;
    endfunction

    function void set_coef(cfg_idx_t idx, coef_word_t data);
      if (idx <= REG_A2) coef_tab[idx] = int'(signed'(data));
    endfunction

    function void take_sample(pcm_t x, logic sor);
      longint       acc;
      longint       y;
      filt_result_t r;
      y = 0;
      r.clipped = 1'b0;
      if (sor) clear_history();
      if (warmup >= WARMUP_SAMPLES) begin
        acc = longint'(coef_tab[REG_B0]) * x
            + longint'(coef_tab[REG_B1]) * x1
            + longint'(coef_tab[REG_B2]) * x2
            - longint'(coef_tab[REG_A1]) * y1
            - longint'(coef_tab[REG_A2]) * y2;
        y = acc / FIX_ONE;
        if (y > PCM_MAX) begin
          y = PCM_MAX;
          r.clipped = 1'b1;
        end else if (y < PCM_MIN) begin
          y = PCM_MIN;
          r.clipped = 1'b1;
        end
      end else begin
        warmup++;
      end
      x2 = x1;
      x1 = x;
      y2 = y1;
      y1 = int'(y);
      r.sample = pcm_t'(y);
      expected_out.push_back(r);
    endfunction

    function void check_output(pcm_t got_sample, logic got_clip);
      filt_result_t want;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected output sample_out=%0d clipped=%0b",
                   $realtime, got_sample, got_clip);
        return;
      end
      want = expected_out.pop_front();
      if (got_sample !== want.sample || got_clip !== want.clipped) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                   $realtime, want.sample, got_sample, want.clipped, got_clip);
      end
    endfunction

    function int unsigned pending();
      return expected_out.size();
    endfunction
  endclass

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       cfg_valid_i       = 1'b0;
  logic       cfg_ready_o;
  cfg_idx_t   cfg_index_i       = '0;
  coef_word_t cfg_data_i        = '0;
  logic       in_valid_i        = 1'b0;
  logic       in_ready_o;
  pcm_t       sample_in_i       = '0;
  logic       start_of_record_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i       = 1'b0;
  pcm_t       sample_out_o;
  logic       clipped_o;

  filter_scoreboard sb;
  bit               hold_off_req = 1'b0;
  bit               src_burst    = 1'b0;
  int unsigned      quiet_cycles = 0;

  biquad_iir_filter_top #(
    .SAMPLE_WIDTH  (SW),
    .COEF_FRAC_BITS(COEF_FRAC_BITS_DEF)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .start_of_record_i(start_of_record_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_out_o     (sample_out_o),
    .clipped_o        (clipped_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_coef(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.take_sample(sample_in_i, start_of_record_i);
      if (out_valid_o && out_ready_i) sb.check_output(sample_out_o, clipped_o);
    end
  end

  // counts cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    bit          sink_burst;
    sink_burst = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if ($urandom_range(0, 47) == 0) sink_burst = !sink_burst;
        stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // valid stays high across back-to-back writes; caller drops it afterwards
  task automatic write_reg(input cfg_idx_t idx, input coef_word_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_coefs(input coef_t c, input bit poke_spare);
    write_reg(REG_B0, c.b0);
    write_reg(REG_B1, c.b1);
    write_reg(REG_B2, c.b2);
    write_reg(REG_A1, c.a1);
    write_reg(REG_A2, c.a2);
    if (poke_spare)
      write_reg(cfg_idx_t'($urandom_range(IDX_SPARE_LO, IDX_TOP)), coef_word_t'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  // valid is only dropped when a gap follows, never dropped and raised in one step
  task automatic send_sample(input pcm_t s, input logic sor);
    int unsigned gap;
    if ($urandom_range(0, 47) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_in_i       <= s;
    start_of_record_i <= sor;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic coef_word_t draw_coef(coef_style_e style, cfg_reg_e r);
    int v;
    case (style)
      COEF_ALL_MAX: v = COEF_MAX;
      COEF_ALL_MIN: v = COEF_MIN;
      COEF_CORNERS: begin
        case ($urandom_range(0, 4))
          0:       v = COEF_MAX;
          1:       v = COEF_MIN;
          2:       v = 0;
          3:       v = COEF_ONE;
          default: v = -COEF_ONE;
        endcase
      end
      COEF_TAME: begin
        if (r == REG_A1) v = int'($urandom_range(0, 4 * COEF_ONE)) - 2 * COEF_ONE;
        else             v = int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
      end
      default: v = int'($urandom());
    endcase
    return coef_word_t'(v);
  endfunction

  function automatic coef_t draw_coefs(coef_style_e style);
    coef_t c;
    c.b0 = draw_coef(style, REG_B0);
    c.b1 = draw_coef(style, REG_B1);
    c.b2 = draw_coef(style, REG_B2);
    c.a1 = draw_coef(style, REG_A1);
    c.a2 = draw_coef(style, REG_A2);
    return c;
  endfunction

  function automatic pcm_t draw_sample();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = PCM_MAX;
          1:       v = PCM_MIN;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      1, 2:    v = int'($urandom_range(0, 512)) - 256;
      default: v = int'($urandom());
    endcase
    return pcm_t'(v);
  endfunction

  // records of random length; a few carry on without a start marker
  task automatic run_records(input int unsigned n_items, input bit with_pressure);
    int unsigned sent;
    int unsigned len;
    bit          carry_on;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
      carry_on = ($urandom_range(0, 15) == 0);
      for (int k = 0; k < len && sent < n_items; k++) begin
        if (with_pressure && sent == PRESSURE_ITEM) hold_off_req = 1'b1;
        send_sample(draw_sample(), (k == 0) && !carry_on);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    coef_t       c;
    coef_style_e style;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients, no start marker: warmup then zero output
    send_sample(pcm_t'(PCM_MAX), 1'b0);
    send_sample(pcm_t'(PCM_MIN), 1'b0);
    send_sample(pcm_t'(12345), 1'b0);
    settle();

    // coefficient extremes drive saturation both ways
    c.b0 = coef_word_t'(COEF_MAX);
    c.b1 = coef_word_t'(COEF_MIN);
    c.b2 = coef_word_t'(COEF_MAX);
    c.a1 = coef_word_t'(COEF_MIN);
    c.a2 = coef_word_t'(COEF_MAX);
    load_coefs(c, 1'b1);
    send_sample(pcm_t'(PCM_MAX), 1'b1);
    send_sample(pcm_t'(PCM_MIN), 1'b0);
    send_sample(pcm_t'(PCM_MIN), 1'b0);
    send_sample(pcm_t'(PCM_MAX), 1'b0);
    send_sample(pcm_t'(0), 1'b0);
    send_sample(pcm_t'(-1), 1'b0);
    send_sample(pcm_t'(1), 1'b0);
    settle();

    // half gain: truncation toward zero, restart mid stream
    c.b0 = coef_word_t'(COEF_HALF);
    c.b1 = '0;
    c.b2 = '0;
    c.a1 = '0;
    c.a2 = '0;
    load_coefs(c, 1'b0);
    send_sample(pcm_t'(5), 1'b1);
    send_sample(pcm_t'(-3), 1'b0);
    send_sample(pcm_t'(-3), 1'b0);
    send_sample(pcm_t'(3), 1'b0);
    send_sample(pcm_t'(-1), 1'b0);
    send_sample(pcm_t'(-3), 1'b1);
    send_sample(pcm_t'(-3), 1'b0);
    send_sample(pcm_t'(-3), 1'b0);
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 1)      style = COEF_ALL_MAX;
      else if (phase == 4) style = COEF_ALL_MIN;
      else                 style = coef_style_e'($urandom_range(COEF_CORNERS, COEF_WILD));
      load_coefs(draw_coefs(style), 1'($urandom_range(0, 1)));
      run_records(PHASE_ITEMS, phase == PRESSURE_PHASE);
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
